[rtl/core/rdf_pkg.sv]
package rdf_pkg;

   localparam int DATA_W = 60;
   localparam int CHAR_W = 8;
   localparam int MAX_DIGITS_DEFAULT = 18;
   localparam int DIV_CNT_W = $clog2(DATA_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_W - 1);

   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      FLD_INT,
      FLD_FRAC,
      FLD_REP,
      FLD_AFTER
   } rdf_field_type;

   typedef enum logic [2:0] {
      ST_ACC,
      ST_LOAD,
      ST_GCD,
      ST_DIV,
      ST_DONE
   } rdf_state_type;

   typedef struct packed {
      logic take;
      logic load;
      logic gcd_step;
      logic div_init;
      logic div_step;
      logic out_load;
   } rdf_cmd_type;

   typedef struct packed {
      logic gcd_done;
   } rdf_status_type;

endpackage

[rtl/core/rdf_dp.sv]
module rdf_dp #(
   parameter int MAX_DIGITS = rdf_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rdf_pkg::CHAR_W-1:0]  req_ch,
   input  rdf_pkg::rdf_cmd_type        cmd,
   output rdf_pkg::rdf_status_type     status,
   output logic [rdf_pkg::DATA_W-1:0]  rsp_numerator,
   output logic [rdf_pkg::DATA_W-1:0]  rsp_denominator,
   output logic                        rsp_overflow
);
   import rdf_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
   localparam logic [DATA_W-1:0] ONE = DATA_W'(1);

   function automatic logic [DATA_W-1:0] mul10(input logic [DATA_W-1:0] x);
      return {x[DATA_W-4:0], 3'b000} + {x[DATA_W-2:0], 1'b0};
   endfunction

   function automatic logic [2*DATA_W-1:0] div_bit(input logic [DATA_W-1:0] rem,
                                                  input logic [DATA_W-1:0] q,
                                                  input logic [DATA_W-1:0] dvs);
      logic [DATA_W:0] rem_sh;
      logic [DATA_W:0] diff;
      rem_sh = {rem, q[DATA_W-1]};
      diff = rem_sh - {1'b0, dvs};
      if (!diff[DATA_W]) begin
         return {diff[DATA_W-1:0], q[DATA_W-2:0], 1'b1};
      end else begin
         return {rem_sh[DATA_W-1:0], q[DATA_W-2:0], 1'b0};
      end
   endfunction

   rdf_field_type     fld_ff, fld_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              too_long_ff, too_long_in;
   logic              rep_seen_ff, rep_seen_in;
   logic [DATA_W-1:0] x1_ff, x1_in;
   logic [DATA_W-1:0] x2_ff, x2_in;
   logic [DATA_W-1:0] pf_ff, pf_in;
   logic [DATA_W-1:0] pfr_ff, pfr_in;

   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] n0_ff, n0_in;
   logic [DATA_W-1:0] d0_ff, d0_in;
   logic [DATA_W-1:0] rn_ff, rn_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   logic              ovf_ff, ovf_in;

   logic [DATA_W-1:0] num_ff, num_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              is_mark;
   logic              is_digit;
   logic [DATA_W-1:0] dig;
   logic [DATA_W-1:0] num_load;
   logic [DATA_W-1:0] den_load;
   logic [DATA_W:0]   diff_ab;
   logic [DATA_W-1:0] diff_ba;

   assign is_mark  = (req_ch == CHAR_DOT) || (req_ch == CHAR_OPEN) || (req_ch == CHAR_CLOSE);
   assign is_digit = (req_ch >= CHAR_ZERO) && (req_ch <= CHAR_NINE);
   assign dig      = {{(DATA_W-4){1'b0}}, req_ch[3:0]};

   always_comb begin
      fld_in      = fld_ff;
      cnt_in      = cnt_ff;
      too_long_in = too_long_ff;
      rep_seen_in = rep_seen_ff;
      x1_in       = x1_ff;
      x2_in       = x2_ff;
      pf_in       = pf_ff;
      pfr_in      = pfr_ff;
      if (cmd.load) begin
         fld_in      = FLD_INT;
         cnt_in      = '0;
         too_long_in = 1'b0;
         rep_seen_in = 1'b0;
         x1_in       = '0;
         x2_in       = '0;
         pf_in       = ONE;
         pfr_in      = ONE;
      end else if (cmd.take) begin
         if (is_mark) begin
            if (fld_ff != FLD_AFTER) begin
               fld_in = rdf_field_type'(fld_ff + 2'd1);
            end
         end else if (is_digit && (fld_ff != FLD_AFTER) && !too_long_ff) begin
            if (cnt_ff >= CNT_MAX) begin
               too_long_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               unique case (fld_ff)
                  FLD_INT: begin
                     x1_in = mul10(x1_ff) + dig;
                     x2_in = mul10(x2_ff) + dig;
                  end
                  FLD_FRAC: begin
                     x1_in  = mul10(x1_ff) + dig;
                     x2_in  = mul10(x2_ff) + dig;
                     pf_in  = mul10(pf_ff);
                     pfr_in = mul10(pfr_ff);
                  end
                  FLD_REP: begin
                     x2_in       = mul10(x2_ff) + dig;
                     pfr_in      = mul10(pfr_ff);
                     rep_seen_in = 1'b1;
                  end
                  FLD_AFTER: begin
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fld_ff      <= FLD_INT;
         cnt_ff      <= '0;
         too_long_ff <= 1'b0;
         rep_seen_ff <= 1'b0;
         x1_ff       <= '0;
         x2_ff       <= '0;
         pf_ff       <= ONE;
         pfr_ff      <= ONE;
      end else begin
         fld_ff      <= fld_in;
         cnt_ff      <= cnt_in;
         too_long_ff <= too_long_in;
         rep_seen_ff <= rep_seen_in;
         x1_ff       <= x1_in;
         x2_ff       <= x2_in;
         pf_ff       <= pf_in;
         pfr_ff      <= pfr_in;
      end
   end

   always_comb begin
      priority if (too_long_ff) begin
         num_load = '0;
         den_load = ONE;
      end else if (rep_seen_ff) begin
         num_load = x2_ff - x1_ff;
         den_load = pfr_ff - pf_ff;
      end else begin
         num_load = x1_ff;
         den_load = pf_ff;
      end
   end

   // Binary gcd: common factors of two are stripped from the operands as well,
   // so the final divisions use the odd part of the gcd left in b.
   assign diff_ab = {1'b0, a_ff} - {1'b0, b_ff};
   assign diff_ba = b_ff - a_ff;

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      n0_in  = n0_ff;
      d0_in  = d0_ff;
      rn_in  = rn_ff;
      rd_in  = rd_ff;
      ovf_in = ovf_ff;
      priority if (cmd.load) begin
         a_in   = num_load;
         b_in   = den_load;
         n0_in  = num_load;
         d0_in  = den_load;
         ovf_in = too_long_ff;
      end else if (cmd.gcd_step && (a_ff != '0)) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in  = a_ff >> 1;
            b_in  = b_ff >> 1;
            n0_in = n0_ff >> 1;
            d0_in = d0_ff >> 1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (!diff_ab[DATA_W]) begin
            a_in = diff_ab[DATA_W-1:0];
         end else begin
            b_in = diff_ba;
         end
      end else if (cmd.div_init) begin
         rn_in = '0;
         rd_in = '0;
      end else if (cmd.div_step) begin
         {rn_in, n0_in} = div_bit(rn_ff, n0_ff, b_ff);
         {rd_in, d0_in} = div_bit(rd_ff, d0_ff, b_ff);
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      n0_ff  <= n0_in;
      d0_ff  <= d0_in;
      rn_ff  <= rn_in;
      rd_ff  <= rd_in;
      ovf_ff <= ovf_in;
   end

   assign num_in     = cmd.out_load ? n0_ff : num_ff;
   assign den_in     = cmd.out_load ? d0_ff : den_ff;
   assign out_ovf_in = cmd.out_load ? ovf_ff : out_ovf_ff;

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      den_ff     <= den_in;
      out_ovf_ff <= out_ovf_in;
   end

   assign status.gcd_done = (a_ff == '0);
   assign rsp_numerator   = num_ff;
   assign rsp_denominator = den_ff;
   assign rsp_overflow    = out_ovf_ff;

endmodule

[rtl/core/rdf_ctrl.sv]
module rdf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rdf_pkg::rdf_status_type status,
   output rdf_pkg::rdf_cmd_type    cmd
);
   import rdf_pkg::*;

   rdf_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_ACC: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_GCD;
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = DIV_LAST;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - DIV_CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/repeating_decimal_to_fraction.sv]
// Characters are taken at one transfer per cycle while a number is being read.
// After the transfer marked last the block passes through a load state, the
// binary gcd steps and the bit-serial division, then writes the output register
// once no earlier result waits there; no character is taken meanwhile.
// Synchronous active-high reset clears the accumulators, the state machine and
// the result valid flag.
module repeating_decimal_to_fraction #(
   parameter int MAX_DIGITS = rdf_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rdf_pkg::CHAR_W-1:0] req_ch,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rdf_pkg::DATA_W-1:0] rsp_numerator,
   output logic [rdf_pkg::DATA_W-1:0] rsp_denominator,
   output logic                       rsp_overflow
);
   import rdf_pkg::*;

   rdf_cmd_type    cmd;
   rdf_status_type status;

   rdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rdf_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .cmd             (cmd),
      .status          (status),
      .rsp_numerator   (rsp_numerator),
      .rsp_denominator (rsp_denominator),
      .rsp_overflow    (rsp_overflow)
   );

`ifndef SYNTHESIS
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_denominator != '0))
      else $error("Result transfer with a zero denominator.");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> ((rsp_numerator == '0) && (rsp_denominator == DATA_W'(1))))
      else $error("Overflow result is not zero over one.");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready)
      else $error("Input still ready after the last character.");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("Result register written without raising valid.");
`endif

endmodule

[verif/rdf_checker.sv]
module rdf_checker
   import rdf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [CHAR_W-1:0] req_ch,
   input  logic              req_last,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [DATA_W-1:0] rsp_numerator,
   input  logic [DATA_W-1:0] rsp_denominator,
   input  logic              rsp_overflow,
   output int                error_count,
   output int                outstanding
);

   typedef struct {
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
      logic              ovf;
   } fraction_type;

   fraction_type  expected_fractions[$];
   int            mismatches = 0;

   rdf_field_type field_pos;
   logic [63:0]   int_val;
   logic [63:0]   frac_val;
   logic [63:0]   rep_val;
   int            int_digits;
   int            frac_digits;
   int            rep_digits;
   logic          digits_exceeded;

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   function automatic void clear_number();
      field_pos       = FLD_INT;
      int_val         = '0;
      frac_val        = '0;
      rep_val         = '0;
      int_digits      = 0;
      frac_digits     = 0;
      rep_digits      = 0;
      digits_exceeded = 1'b0;
   endfunction

   function automatic logic [63:0] ten_to(input int n);
      logic [63:0] v;
      v = 64'd1;
      for (int i = 0; i < n && i < 19; i++) v = v * 10;
      return v;
   endfunction

   function automatic logic [63:0] common_divisor(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic void absorb_char(input logic [CHAR_W-1:0] c);
      logic [63:0] digit;
      digit = 64'(c - CHAR_ZERO);
      if (c == CHAR_DOT || c == CHAR_OPEN || c == CHAR_CLOSE) begin
         if (field_pos != FLD_AFTER) field_pos = rdf_field_type'(field_pos + 2'd1);
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE && field_pos != FLD_AFTER
                   && !digits_exceeded) begin
         if (int_digits + frac_digits + rep_digits >= MAX_DIGITS_DEFAULT) begin
            digits_exceeded = 1'b1;
         end else begin
            case (field_pos)
               FLD_INT: begin
                  int_val = int_val * 10 + digit;
                  int_digits++;
               end
               FLD_FRAC: begin
                  frac_val = frac_val * 10 + digit;
                  frac_digits++;
               end
               default: begin
                  rep_val = rep_val * 10 + digit;
                  rep_digits++;
               end
            endcase
         end
      end
   endfunction

   function automatic fraction_type reduced_fraction();
      fraction_type f;
      logic [63:0]  num;
      logic [63:0]  den;
      logic [63:0]  x1;
      logic [63:0]  x2;
      logic [63:0]  g;
      if (digits_exceeded) begin
         num = 64'd0;
         den = 64'd1;
      end else begin
         x1 = int_val * ten_to(frac_digits) + frac_val;
         if (rep_digits == 0) begin
            num = x1;
            den = ten_to(frac_digits);
         end else begin
            x2  = x1 * ten_to(rep_digits) + rep_val;
            num = x2 - x1;
            den = ten_to(frac_digits + rep_digits) - ten_to(frac_digits);
         end
         if (den == 0) den = 64'd1;
         g = common_divisor(num, den);
         if (g != 0) begin
            num = num / g;
            den = den / g;
         end
      end
      f.num = num[DATA_W-1:0];
      f.den = den[DATA_W-1:0];
      f.ovf = digits_exceeded;
      return f;
   endfunction

   always @(posedge clock) begin
      fraction_type want;
      if (reset) begin
         clear_number();
         expected_fractions.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_fractions.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: got %0d/%0d overflow %0b",
                           rsp_numerator, rsp_denominator, rsp_overflow);
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_numerator !== want.num || rsp_denominator !== want.den
                   || rsp_overflow !== want.ovf) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %0d/%0d overflow %0b, got %0d/%0d overflow %0b",
                              want.num, want.den, want.ovf,
                              rsp_numerator, rsp_denominator, rsp_overflow);
               end
            end
         end
         if (req_valid && req_ready) begin
            absorb_char(req_ch);
            if (req_last) begin
               expected_fractions = {expected_fractions, reduced_fraction()};
               clear_number();
            end
         end
      end
      error_count <= mismatches;
      outstanding <= expected_fractions.size();
   end

endmodule

[verif/tb_top.sv]
module tb_top;

   import rdf_pkg::*;

   localparam int RESET_CYCLES = 5;
   localparam int PHASE_ITEMS  = 335;
   localparam int DRAIN_CYCLES = 400;
   localparam int CYCLE_LIMIT  = 1500000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CHAR_W-1:0] req_ch = '0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DATA_W-1:0] rsp_numerator;
   logic [DATA_W-1:0] rsp_denominator;
   logic              rsp_overflow;

   int                error_count;
   int                outstanding;
   int                sender_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                sent_items = 0;
   int                cycle_count = 0;

   repeating_decimal_to_fraction u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_numerator   (rsp_numerator),
      .rsp_denominator (rsp_denominator),
      .rsp_overflow    (rsp_overflow)
   );

   rdf_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_numerator   (rsp_numerator),
      .rsp_denominator (rsp_denominator),
      .rsp_overflow    (rsp_overflow),
      .error_count     (error_count),
      .outstanding     (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] c, input logic is_last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      req_last  <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   function automatic logic [CHAR_W-1:0] pick_digit();
      int r;
      r = $urandom_range(0, 7);
      if (r < 2) return CHAR_NINE;
      if (r == 2) return CHAR_ZERO;
      return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_marker();
      case ($urandom_range(0, 2))
         0:       return CHAR_DOT;
         1:       return CHAR_OPEN;
         default: return CHAR_CLOSE;
      endcase
   endfunction

   task automatic send_random_number();
      logic [CHAR_W-1:0] chars[$];
      int                total;
      int                n_int;
      int                n_frac;
      int                n_rep;
      int                r;
      if ($urandom_range(0, 99) < 78) begin
         r = $urandom_range(0, 9);
         if (r == 0) total = MAX_DIGITS_DEFAULT;
         else if (r == 1) total = $urandom_range(MAX_DIGITS_DEFAULT + 1, MAX_DIGITS_DEFAULT + 4);
         else total = $urandom_range(0, 12);
         n_int  = $urandom_range(0, total);
         n_frac = $urandom_range(0, total - n_int);
         n_rep  = total - n_int - n_frac;
         repeat (n_int) chars = {chars, pick_digit()};
         if (n_frac > 0 || n_rep > 0 || $urandom_range(0, 3) == 0) chars = {chars, CHAR_DOT};
         repeat (n_frac) chars = {chars, pick_digit()};
         if (n_rep > 0) begin
            chars = {chars, CHAR_OPEN};
            repeat (n_rep) chars = {chars, pick_digit()};
            if ($urandom_range(0, 7) != 0) chars = {chars, CHAR_CLOSE};
            if ($urandom_range(0, 9) == 0) begin
               chars = {chars, pick_marker()};
               chars = {chars, pick_digit()};
            end
         end
      end else begin
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 2))
               0:       chars = {chars, pick_digit()};
               1:       chars = {chars, pick_marker()};
               default: chars = {chars, CHAR_W'($urandom_range(0, 255))};
            endcase
         end
      end
      if (chars.size() == 0) chars = {chars, CHAR_ZERO};
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
   endtask

   initial begin
      int phase_goal;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Bytes outside the digit range, digits in the trailing field and a last
      // transfer on an ignored character must all leave the value untouched.
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char("7", 1'b1);
      send_text("x");
      send_text("1.2(3)");
      send_text("...5");
      send_text("9.(9)");

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 0;
            end
            1: begin
               sender_idle_pct = 66;
               recv_stall_pct  = 0;
            end
            2: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 66;
            end
            default: begin
               sender_idle_pct = 14;
               recv_stall_pct  = 14;
            end
         endcase
         phase_goal = sent_items + PHASE_ITEMS;
         while (sent_items < phase_goal) send_random_number();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/rdf_pkg.sv
rtl/core/rdf_dp.sv
rtl/core/rdf_ctrl.sv
rtl/core/repeating_decimal_to_fraction.sv
verif/rdf_checker.sv
verif/tb_top.sv
